// ===== rtl/core/abrh_pkg.sv =====
// Package for the abundance resampling histogram core: sizes, op and status
// codes, and the request/response structs passed between the sub-blocks.
// No dependencies.
`default_nettype none

package abrh_pkg;

  localparam int MAX_SPECIES = 1024;
  localparam int COUNT_BITS  = 32;
  localparam int SPECIES_W   = $clog2(MAX_SPECIES);
  localparam int LOADED_W    = $clog2(MAX_SPECIES + 1);
  localparam int FRAC_W      = 32;
  localparam int HIST_W      = 32;
  localparam int ABUND_W     = 24;
  localparam int PROD_W      = FRAC_W + COUNT_BITS;

  localparam logic [HIST_W-1:0] HIST_MAX = {HIST_W{1'b1}};

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic                  start;
    logic [FRAC_W-1:0]     frac;
    logic [COUNT_BITS-1:0] total;
    logic [SPECIES_W-1:0]  last;
  } srch_req_t;

  typedef struct packed {
    logic                 done;
    logic [SPECIES_W-1:0] index;
  } srch_rsp_t;

  typedef struct packed {
    logic                 valid;
    logic                 incr;
    logic [SPECIES_W-1:0] addr;
  } hist_req_t;

  typedef struct packed {
    logic              ready;
    logic              done;
    logic [HIST_W-1:0] count;
  } hist_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/abrh_search.sv =====
// Cumulative-count table with a binary search driven by one shared compare unit.
// Depends on abrh_pkg.
`default_nettype none

module abrh_search import abrh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [SPECIES_W-1:0]  wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  input  srch_req_t             req,
  output srch_rsp_t             rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;

  logic [COUNT_BITS-1:0] mem [MAX_SPECIES];

  logic [1:0]            state;
  logic [SPECIES_W-1:0]  lo;
  logic [SPECIES_W-1:0]  hi;
  logic [SPECIES_W-1:0]  mid;
  logic [SPECIES_W-1:0]  last_q;
  logic [PROD_W-1:0]     product;
  logic [COUNT_BITS-1:0] rd_data;

  logic [SPECIES_W-1:0]  mid_next;
  logic [SPECIES_W:0]    lohi_sum;
  logic [PROD_W-1:0]     mul_out;
  logic [COUNT_BITS-1:0] prod_hi;
  logic                  prod_lo_zero;
  logic                  hit;
  logic                  more;

  assign lohi_sum     = {1'b0, lo} + {1'b0, hi};
  assign mid_next     = lohi_sum[SPECIES_W:1];
  assign mul_out      = PROD_W'(req.frac) * PROD_W'(req.total);
  assign prod_hi      = product[PROD_W-1:FRAC_W];
  assign prod_lo_zero = (product[FRAC_W-1:0] == '0);
  // r*total <= cum*2^32, only against a nonzero entry
  assign hit  = (rd_data != '0) &&
                ((prod_hi < rd_data) || ((prod_hi == rd_data) && prod_lo_zero));
  assign more = (lo < hi);

  assign rsp.done  = (state == S_FETCH) && !more;
  assign rsp.index = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) state <= S_FETCH;
        end
        S_FETCH: begin
          state <= more ? S_CMP : S_IDLE;
        end
        S_CMP: begin
          state <= S_FETCH;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.start) begin
      lo      <= '0;
      hi      <= req.last;
      last_q  <= req.last;
      product <= mul_out;
    end
    if (state == S_FETCH) begin
      mid     <= mid_next;
      rd_data <= mem[mid_next];
    end
    if (state == S_CMP) begin
      if (hit) hi <= mid;
      else     lo <= mid + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (rsp.index <= last_q))
    else $error("search result beyond last loaded species");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (lo <= mid && mid < hi))
    else $error("search midpoint outside bounds");

endmodule

`default_nettype wire

// ===== rtl/core/abrh_hist.sv =====
// Histogram store: read-modify-write with saturating increment or clear, and
// a clearing pass after reset. Depends on abrh_pkg.
`default_nettype none

module abrh_hist import abrh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  hist_req_t req,
  output hist_rsp_t rsp
);

  localparam logic [1:0] H_CLEAR = 2'd0;
  localparam logic [1:0] H_IDLE  = 2'd1;
  localparam logic [1:0] H_WRITE = 2'd2;

  localparam logic [SPECIES_W-1:0] LAST_ENTRY = SPECIES_W'(MAX_SPECIES - 1);

  logic [HIST_W-1:0] mem [MAX_SPECIES];

  logic [1:0]           state;
  logic [SPECIES_W-1:0] clr_ptr;
  logic [SPECIES_W-1:0] addr_q;
  logic                 incr_q;
  logic [HIST_W-1:0]    rd_data;

  logic [HIST_W-1:0]    new_val;
  logic                 we;
  logic [SPECIES_W-1:0] wa;
  logic [HIST_W-1:0]    wd;

  always_comb begin
    if (!incr_q)                new_val = '0;
    else if (rd_data == HIST_MAX) new_val = rd_data;
    else                        new_val = rd_data + 1'b1;
  end

  assign we = (state == H_CLEAR) || (state == H_WRITE);
  assign wa = (state == H_CLEAR) ? clr_ptr : addr_q;
  assign wd = (state == H_CLEAR) ? '0 : new_val;

  assign rsp.ready = (state == H_IDLE);
  assign rsp.done  = (state == H_WRITE);
  assign rsp.count = incr_q ? new_val : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= H_CLEAR;
      clr_ptr <= '0;
    end else begin
      case (state)
        H_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == LAST_ENTRY) state <= H_IDLE;
        end
        H_IDLE: begin
          if (req.valid) state <= H_WRITE;
        end
        H_WRITE: begin
          state <= H_IDLE;
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == H_IDLE && req.valid) begin
      rd_data <= mem[req.addr];
      addr_q  <= req.addr;
      incr_q  <= req.incr;
    end
    if (we) mem[wa] <= wd;
  end

  a_sweep_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !rsp.ready)
    else $error("histogram ready before clearing pass");

endmodule

`default_nettype wire

// ===== rtl/core/abundance_resampling_histogram_core.sv =====
// Abundance resampling histogram core: top level with the item sequencer,
// table bookkeeping and output register. Depends on abrh_pkg, abrh_search
// and abrh_hist.
//
// Multinomial resampler. A load beat appends one species abundance to the
// cumulative table and returns the species index and new total. A draw beat
// multiplies its 32-bit fraction by the total, binary-searches the cumulative
// table for the species whose interval holds the product, and bumps that
// species' saturating histogram count. A read beat returns a count and clears
// it. A clear beat empties the table but keeps the histogram.
// One item is in flight at a time. After the accepting edge, a load, a clear
// or a rejected item goes straight to the output stage; a read first passes
// through the histogram read-modify-write; a draw first runs the search loop,
// whose length grows with the number of loaded species, and then the
// histogram update.
// Each search step is one registered table read followed by one compare.
// After reset the histogram is zeroed by a pass over all 1024 entries, one
// entry per cycle, during which in_stall stays high. A finished result waits
// in the output register, so the next item is taken while it is still stalled.
`default_nettype none

module abundance_resampling_histogram_core import abrh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic [ABUND_W-1:0]   abundance,
  input  logic [FRAC_W-1:0]    random_fraction,
  input  logic [SPECIES_W-1:0] species_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SPECIES_W-1:0] chosen_species,
  output logic [HIST_W-1:0]    species_count,
  output logic [1:0]           status
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_SRCH = 2'd1;
  localparam logic [1:0] T_HIST = 2'd2;
  localparam logic [1:0] T_OUT  = 2'd3;

  localparam logic [LOADED_W-1:0] MAX_LOADED = LOADED_W'(MAX_SPECIES);

  logic [1:0]            state;
  logic [LOADED_W-1:0]   loaded;
  logic [COUNT_BITS-1:0] total_count;

  // result held until the output register is free
  logic [SPECIES_W-1:0]  res_chosen;
  logic [HIST_W-1:0]     res_count;
  logic [1:0]            res_status;

  logic                  accept;
  logic                  out_free;
  logic [COUNT_BITS:0]   sum;
  logic                  load_ok;
  logic                  draw_ok;
  logic                  bad_idx;
  logic                  wr_en;
  srch_req_t             srch_req;
  srch_rsp_t             srch_rsp;
  hist_req_t             hist_req;
  hist_rsp_t             hist_rsp;

  assign in_stall = !((state == T_IDLE) && hist_rsp.ready);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // a load is refused when the table is full or the total would carry out
  assign sum     = {1'b0, total_count} + (COUNT_BITS+1)'(abundance);
  assign load_ok = (loaded != MAX_LOADED) && !sum[COUNT_BITS];
  assign draw_ok = (total_count != '0) && (loaded != '0);
  assign bad_idx = ({1'b0, species_index} >= MAX_LOADED);

  assign wr_en = accept && (op == OP_LOAD) && load_ok;

  assign srch_req.start = accept && (op == OP_DRAW) && draw_ok;
  assign srch_req.frac  = random_fraction;
  assign srch_req.total = total_count;
  assign srch_req.last  = SPECIES_W'(loaded - 1'b1);

  // draw: bump the found species; read: fetch and clear the given one
  assign hist_req.valid = (accept && (op == OP_READ) && !bad_idx) ||
                          ((state == T_SRCH) && srch_rsp.done);
  assign hist_req.incr  = (state == T_SRCH);
  assign hist_req.addr  = (state == T_SRCH) ? srch_rsp.index : species_index;

  abrh_search u_search (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (SPECIES_W'(loaded)),
    .wr_data (sum[COUNT_BITS-1:0]),
    .req     (srch_req),
    .rsp     (srch_rsp)
  );

  abrh_hist u_hist (
    .clk (clk),
    .rst (rst),
    .req (hist_req),
    .rsp (hist_rsp)
  );

  // sequencer and table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      loaded      <= '0;
      total_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      // raise the beat as a new result lands; drop it once taken
      if (state == T_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            case (op)
              OP_LOAD: begin
                if (load_ok) begin
                  total_count <= sum[COUNT_BITS-1:0];
                  loaded      <= loaded + 1'b1;
                end
                state <= T_OUT;
              end
              OP_DRAW: begin
                state <= draw_ok ? T_SRCH : T_OUT;
              end
              OP_READ: begin
                state <= bad_idx ? T_OUT : T_HIST;
              end
              OP_CLEAR: begin
                total_count <= '0;
                loaded      <= '0;
                state       <= T_OUT;
              end
              default: begin
                state <= T_OUT;
              end
            endcase
          end
        end
        T_SRCH: begin
          if (srch_rsp.done) state <= T_HIST;
        end
        T_HIST: begin
          if (hist_rsp.done) state <= T_OUT;
        end
        T_OUT: begin
          if (out_free) state <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD: begin
              res_chosen <= load_ok ? SPECIES_W'(loaded) : '0;
              res_count  <= load_ok ? HIST_W'(sum[COUNT_BITS-1:0]) : '0;
              res_status <= load_ok ? ST_OK : ST_FULL;
            end
            OP_DRAW: begin
              res_chosen <= '0;
              res_count  <= '0;
              res_status <= draw_ok ? ST_OK : ST_EMPTY;
            end
            OP_READ: begin
              res_chosen <= species_index;
              res_count  <= '0;
              res_status <= bad_idx ? ST_BAD : ST_OK;
            end
            default: begin
              res_chosen <= '0;
              res_count  <= '0;
              res_status <= ST_OK;
            end
          endcase
        end
      end
      T_SRCH: begin
        if (srch_rsp.done) res_chosen <= srch_rsp.index;
      end
      T_HIST: begin
        if (hist_rsp.done) res_count <= hist_rsp.count;
      end
      T_OUT: begin
        if (out_free) begin
          chosen_species <= res_chosen;
          species_count  <= res_count;
          status         <= res_status;
        end
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  a_hist_idle: assert property (@(posedge clk) disable iff (rst)
    hist_req.valid |-> hist_rsp.ready)
    else $error("histogram request while histogram busy");

  a_draw_nonempty: assert property (@(posedge clk) disable iff (rst)
    srch_req.start |-> (total_count != '0 && loaded != '0))
    else $error("search started on an empty table");

  a_loaded_range: assert property (@(posedge clk) disable iff (rst)
    loaded <= MAX_LOADED)
    else $error("species count beyond table depth");

endmodule

`default_nettype wire
